### rtl/pms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pms_pkg: shared constants and types for the prescale and match search
// Field widths, search limits and sequencer states.
// ----------------------------------------------------------------------------
package pms_pkg;

	localparam int CNT_W      = 32;
	localparam int PRESCALE_W = 9;
	localparam int MATCH_W    = 17;
	localparam int QUOT_W     = 16;
	localparam int ALU_W      = MATCH_W + 1;

	localparam logic [MATCH_W-1:0]    MATCH_MAX    = MATCH_W'(65536);
	localparam logic [PRESCALE_W-1:0] PRESCALE_MAX = PRESCALE_W'(256);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_ADJUST
	} state_t;

endpackage
`default_nettype wire

### rtl/prescale_match_search_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prescale_match_search_unit: timer prescale and period search
// Finds the prescale and match pair whose product best fits a tick count.
// ----------------------------------------------------------------------------
// Usage:
//   Drive tick_count and raise start while busy is low; the word is taken at
//   that clock edge. The result appears on prescale and match_value for one
//   cycle with done high. The receiver cannot stall; it must take the result
//   in that cycle.
//   A count of at most 65536 is answered directly: done rises in the cycle
//   after start is taken, and busy stays low. A larger count starts a search
//   that walks the match value down from 65536 while keeping quotient and
//   remainder updated through one shared add/subtract unit: each candidate
//   gets an evaluate step and then a correction step, which repeats each
//   time the quotient steps up. The search stops at the first exact divisor
//   or once the quotient passes 256; the quotient steps up at most 256 times.
//   Counts of 257 * 65536 or more finish at the first evaluate step. busy
//   is high for the whole search.
//   Reset returns the sequencer to idle and clears done; no result is lost
//   other than one in flight at reset.
// ----------------------------------------------------------------------------
module prescale_match_search_unit (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	output logic                              busy,
	input  wire  [pms_pkg::CNT_W-1:0]         tick_count,
	output logic                              done,
	output logic [pms_pkg::PRESCALE_W-1:0]    prescale,
	output logic [pms_pkg::MATCH_W-1:0]       match_value
);

	pms_pkg::state_t state_q, state_d;

	logic [pms_pkg::MATCH_W-1:0]    m_q;
	logic [pms_pkg::QUOT_W-1:0]     quot_q;
	logic [pms_pkg::MATCH_W-1:0]    rem_q;
	logic [pms_pkg::MATCH_W-1:0]    best_rem_q;
	logic [pms_pkg::PRESCALE_W-1:0] best_p_q;
	logic [pms_pkg::MATCH_W-1:0]    best_m_q;

	logic accept;
	logic small_req;
	logic load_small;
	logic load_large;
	logic do_eval;
	logic do_adjust;

	logic                         over_limit;
	logic                         exact;
	logic [pms_pkg::ALU_W-1:0]    alu_b;
	logic [pms_pkg::ALU_W-1:0]    alu_sum;
	logic                         rem_ge;

	assign accept    = start && !busy;
	assign small_req = (tick_count <= {{(pms_pkg::CNT_W-pms_pkg::MATCH_W){1'b0}},
		pms_pkg::MATCH_MAX});

	// shared unit: rem + quot when stepping the match down, rem - m when correcting
	assign alu_b   = do_adjust ? ~{1'b0, m_q} : {{(pms_pkg::ALU_W-pms_pkg::QUOT_W){1'b0}}, quot_q};
	assign alu_sum = {1'b0, rem_q} + alu_b + {{(pms_pkg::ALU_W-1){1'b0}}, do_adjust};
	assign rem_ge  = !alu_sum[pms_pkg::ALU_W-1];

	assign over_limit = (quot_q > {{(pms_pkg::QUOT_W-pms_pkg::PRESCALE_W){1'b0}},
		pms_pkg::PRESCALE_MAX});
	assign exact      = (rem_q == '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pms_pkg::ST_IDLE: begin
				if (accept && !small_req)
					state_d = pms_pkg::ST_EVAL;
			end
			pms_pkg::ST_EVAL: begin
				if (over_limit || exact)
					state_d = pms_pkg::ST_IDLE;
				else
					state_d = pms_pkg::ST_ADJUST;
			end
			pms_pkg::ST_ADJUST: begin
				if (!rem_ge)
					state_d = pms_pkg::ST_EVAL;
			end
			default: state_d = pms_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy       = 1'b1;
		load_small = 1'b0;
		load_large = 1'b0;
		do_eval    = 1'b0;
		do_adjust  = 1'b0;
		unique case (state_q)
			pms_pkg::ST_IDLE: begin
				busy       = 1'b0;
				load_small = accept && small_req;
				load_large = accept && !small_req;
			end
			pms_pkg::ST_EVAL:   do_eval   = 1'b1;
			pms_pkg::ST_ADJUST: do_adjust = 1'b1;
			default:            busy      = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pms_pkg::ST_IDLE;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= load_small || (do_eval && (over_limit || exact));
		end
	end

	always_ff @(posedge clk) begin
		if (load_small) begin
			prescale    <= pms_pkg::PRESCALE_W'(1);
			match_value <= tick_count[pms_pkg::MATCH_W-1:0];
		end
		if (load_large) begin
			m_q        <= pms_pkg::MATCH_MAX;
			quot_q     <= tick_count[pms_pkg::CNT_W-1:pms_pkg::CNT_W-pms_pkg::QUOT_W];
			rem_q      <= {1'b0, tick_count[pms_pkg::CNT_W-pms_pkg::QUOT_W-1:0]};
			best_rem_q <= '1;
			best_p_q   <= pms_pkg::PRESCALE_W'(1);
			best_m_q   <= pms_pkg::MATCH_MAX;
		end
		if (do_eval) begin
			if (over_limit) begin
				prescale    <= best_p_q;
				match_value <= best_m_q;
			end else if (exact) begin
				prescale    <= quot_q[pms_pkg::PRESCALE_W-1:0];
				match_value <= m_q;
			end else begin
				// keep the earlier match on equal remainders
				if (rem_q < best_rem_q) begin
					best_rem_q <= rem_q;
					best_p_q   <= quot_q[pms_pkg::PRESCALE_W-1:0];
					best_m_q   <= m_q;
				end
				m_q   <= m_q - pms_pkg::MATCH_W'(1);
				rem_q <= alu_sum[pms_pkg::MATCH_W-1:0];
			end
		end
		if (do_adjust && rem_ge) begin
			rem_q  <= alu_sum[pms_pkg::MATCH_W-1:0];
			quot_q <= quot_q + pms_pkg::QUOT_W'(1);
		end
	end

`ifndef SYNTHESIS
	a_rem_below_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pms_pkg::ST_EVAL) |-> (rem_q < m_q))
		else $error("remainder not below match during evaluate");

	a_prescale_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (prescale >= pms_pkg::PRESCALE_W'(1) && prescale <= pms_pkg::PRESCALE_MAX))
		else $error("prescale out of range");

	a_match_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (match_value <= pms_pkg::MATCH_MAX))
		else $error("match value out of range");

	a_large_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !small_req) |=> (busy && !done))
		else $error("large request did not start a search");

	a_adjust_quotient: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pms_pkg::ST_ADJUST) |->
		(quot_q <= pms_pkg::QUOT_W'(258)))
		else $error("quotient ran away during correction");
`endif

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: prescale and match search unit testbench
// Feeds tick counts through the start/busy handshake and checks every
// prescale and match pair on the done strobe against a behavioral search
// computed here. The stimulus is a directed set followed by random counts
// chosen so that most searches stay short.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned IDLE_LIMIT = 600000;
	localparam int unsigned TAIL_CYCLES = 8;

	typedef struct {
		logic [pms_pkg::CNT_W-1:0]      count;
		logic [pms_pkg::PRESCALE_W-1:0] prescale;
		logic [pms_pkg::MATCH_W-1:0]    match_value;
	} pair_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           start = 1'b0;
	logic [pms_pkg::CNT_W-1:0]      tick_count = '0;
	logic                           busy;
	logic                           done;
	logic [pms_pkg::PRESCALE_W-1:0] prescale;
	logic [pms_pkg::MATCH_W-1:0]    match_value;

	pair_t       wanted_pairs[$];
	int unsigned error_count = 0;
	int unsigned words_sent = 0;
	int unsigned pairs_checked = 0;
	int unsigned idle_cycles = 0;
	int unsigned idle_pct = 0;

	prescale_match_search_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.tick_count  (tick_count),
		.done        (done),
		.prescale    (prescale),
		.match_value (match_value)
	);

	always #4 clk = ~clk;

	// Best prescale/match pair for one tick count.
	function automatic pair_t best_pair(input logic [pms_pkg::CNT_W-1:0] cnt);
		pair_t           res;
		longint unsigned c;
		longint unsigned bp;
		longint unsigned bm;
		longint unsigned brem;
		longint unsigned lowest;
		longint unsigned k;
		longint unsigned q;
		longint unsigned r;
		bit              exact;
		c = cnt;
		bp = 1;
		bm = pms_pkg::MATCH_MAX;
		brem = c;
		exact = 1'b0;
		if (c <= pms_pkg::MATCH_MAX) begin
			bm = c;
		end else begin
			lowest = c / (pms_pkg::PRESCALE_MAX + 1);
			for (k = pms_pkg::MATCH_MAX; k > lowest && k > 0 && !exact; k--) begin
				q = c / k;
				r = c % k;
				if (q <= pms_pkg::PRESCALE_MAX) begin
					if (r == 0) begin
						bp = q;
						bm = k;
						exact = 1'b1;
					end else if (r < brem) begin
						brem = r;
						bp = q;
						bm = k;
					end
				end
			end
		end
		res.count = cnt;
		res.prescale = bp[pms_pkg::PRESCALE_W-1:0];
		res.match_value = bm[pms_pkg::MATCH_W-1:0];
		return res;
	endfunction

	function automatic int unsigned idle_gap();
		int unsigned n;
		n = 0;
		while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct && n < 40)
			n++;
		return n;
	endfunction

	// Random count, weighted toward short searches.
	function automatic logic [pms_pkg::CNT_W-1:0] rand_count();
		int unsigned               sel;
		logic [pms_pkg::CNT_W-1:0] c;
		sel = $urandom_range(0, 99);
		if (sel < 25) begin
			c = $urandom_range(0, 65536);
		end else if (sel < 55) begin
			c = $urandom();
			// keep long mid-range searches out of the random mix
			if (c > 65536 && c < 32'd16384000)
				c[31] = 1'b1;
		end else if (sel < 78) begin
			c = $urandom_range(2, 256) * (65536 - $urandom_range(0, 300));
		end else begin
			c = $urandom_range(32'd16384000, 32'd16843752);
		end
		return c;
	endfunction

	task automatic send_count(input logic [pms_pkg::CNT_W-1:0] c);
		int unsigned gap;
		gap = idle_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		tick_count <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		wanted_pairs.push_back(best_pair(c));
		words_sent++;
	endtask

	// Hold start low until every pending result is back.
	task automatic drain_pending();
		start <= 1'b0;
		@(posedge clk);
		while (wanted_pairs.size() > 0)
			@(posedge clk);
	endtask

	task automatic test_small_counts();
		logic [pms_pkg::CNT_W-1:0] list[$];
		list = '{0, 1, 2, 3, 255, 256, 257, 32768, 65535, 65536};
		foreach (list[i])
			send_count(list[i]);
	endtask

	task automatic test_unreachable_counts();
		logic [pms_pkg::CNT_W-1:0] list[$];
		list = '{32'd16842752, 32'd16842753, 32'h8000_0000, 32'hFFFF_FFFF};
		foreach (list[i])
			send_count(list[i]);
	endtask

	task automatic test_search_counts();
		logic [pms_pkg::CNT_W-1:0] list[$];
		// 65537 is prime: the search walks the whole range
		list = '{32'd65537, 32'd131072, 32'd131070, 32'd16777216, 32'd16777215,
			32'd16777217, 32'd16842751};
		list.push_back(255 * 65535);
		foreach (list[i])
			send_count(list[i]);
	endtask

	task automatic test_random_mix();
		int unsigned phase_pct[4];
		phase_pct = '{0, 68, 0, 32};
		for (int p = 0; p < 4; p++) begin
			idle_pct = phase_pct[p];
			for (int i = 0; i < 20; i++)
				send_count(rand_count());
			if (p == 1)
				drain_pending();
		end
		idle_pct = 0;
	endtask

	always @(posedge clk) begin
		pair_t exp_pair;
		if (done) begin
			if (wanted_pairs.size() == 0) begin
				$display("%0t: unexpected result prescale %0d match %0d",
					$time, prescale, match_value);
				error_count++;
			end else begin
				exp_pair = wanted_pairs.pop_front();
				pairs_checked++;
				if (prescale !== exp_pair.prescale) begin
					$display("%0t: count %0d prescale expected %0d actual %0d",
						$time, exp_pair.count, exp_pair.prescale, prescale);
					error_count++;
				end
				if (match_value !== exp_pair.match_value) begin
					$display("%0t: count %0d match expected %0d actual %0d",
						$time, exp_pair.count, exp_pair.match_value, match_value);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_small_counts();
		test_unreachable_counts();
		test_search_counts();
		test_random_mix();
		drain_pending();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d tick counts (small, out of range, exact and nearest fits),",
			words_sent);
		$display("checked %0d results with sender gaps of 0, 68 and 32 percent.",
			pairs_checked);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
